@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the rasterizer RTL.
// Needs no other file; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ hw/rtl/mer_pkg.sv @@
// Package of the midpoint ellipse rasterizer: widths, command codes,
// controller states and the command and status structs. Depends on nothing.
package mer_pkg;

    localparam int MER_COORD_BITS  = 12;
    localparam int MER_RADIUS_BITS = 10;

    localparam logic MER_CMD_START = 1'b0;
    localparam logic MER_CMD_STEP  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_S1,
        ST_S2,
        ST_S3,
        ST_S4,
        ST_S5,
        ST_R1,
        ST_R2,
        ST_R3,
        ST_R4,
        ST_R5,
        ST_X1,
        ST_X2
    } t_mer_state;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_RX_RX,
        MUL_RY_RY,
        MUL_RX2_RY,
        MUL_RX2_RY2,
        MUL_T_T,
        MUL_RY2_P,
        MUL_U_U,
        MUL_RX2_P
    } t_mul_op;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_RX2,
        WR_RY2,
        WR_START_DEC,
        WR_C,
        WR_ACC,
        WR_REGION_DEC
    } t_wr_op;

    typedef struct packed {
        logic    load_geom;
        t_mul_op mul_op;
        t_wr_op  wr_op;
        logic    step_move;
        logic    step_dec;
        logic    out_load;
    } t_mer_cmd;

    typedef struct packed {
        logic active;
        logic in_r2;
        logic dx_ge_dy;
        logic out_free;
    } t_mer_sts;

endpackage

@@ hw/rtl/mer_in_if.sv @@
// Input channel of the rasterizer: valid, ready and one command beat.
// Depends on mer_pkg for the default widths.
interface mer_in_if #(
    parameter int COORD_BITS  = mer_pkg::MER_COORD_BITS,
    parameter int RADIUS_BITS = mer_pkg::MER_RADIUS_BITS
);
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0] radius_x;
    logic [RADIUS_BITS-1:0] radius_y;

    modport source (
        output valid, cmd, center_x, center_y, radius_x, radius_y,
        input  ready
    );
    modport sink (
        input  valid, cmd, center_x, center_y, radius_x, radius_y,
        output ready
    );
endinterface

@@ hw/rtl/mer_out_if.sv @@
// Result channel of the rasterizer: valid, ready and one point-set beat.
// Depends on mer_pkg for the default width.
interface mer_out_if #(
    parameter int COORD_BITS = mer_pkg::MER_COORD_BITS
);
    logic                   valid;
    logic                   ready;
    logic [COORD_BITS:0]    col_plus;
    logic signed [COORD_BITS:0] col_minus;
    logic [COORD_BITS:0]    row_plus;
    logic signed [COORD_BITS:0] row_minus;
    logic                   region;
    logic                   last;

    modport source (
        output valid, col_plus, col_minus, row_plus, row_minus, region, last,
        input  ready
    );
    modport sink (
        input  valid, col_plus, col_minus, row_plus, row_minus, region, last,
        output ready
    );
endinterface

@@ hw/rtl/mer_ctrl.sv @@
// Sequencer of the rasterizer: start setup, region change and step phases.
// Depends on mer_pkg and assert_macros.svh; drives mer_dp by command struct.
`include "assert_macros.svh"

module mer_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_cmd,
    output logic              o_in_ready,
    input  mer_pkg::t_mer_sts i_sts,
    output mer_pkg::t_mer_cmd o_cmd
);
    import mer_pkg::*;

    t_mer_state r_state;
    t_mer_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_in_ready      = 1'b0;
        o_cmd.load_geom = 1'b0;
        o_cmd.mul_op    = MUL_NONE;
        o_cmd.wr_op     = WR_NONE;
        o_cmd.step_move = 1'b0;
        o_cmd.step_dec  = 1'b0;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_cmd == MER_CMD_START) begin
                        o_cmd.load_geom = 1'b1;
                        n_state         = ST_S1;
                    end else if (i_sts.active) begin
                        if (!i_sts.in_r2 && i_sts.dx_ge_dy) begin
                            n_state = ST_R1;
                        end else begin
                            n_state = ST_X1;
                        end
                    end
                end
            end
            ST_S1: begin
                o_cmd.mul_op = MUL_RX_RX;
                n_state      = ST_S2;
            end
            ST_S2: begin
                o_cmd.wr_op  = WR_RX2;
                o_cmd.mul_op = MUL_RY_RY;
                n_state      = ST_S3;
            end
            ST_S3: begin
                o_cmd.wr_op  = WR_RY2;
                o_cmd.mul_op = MUL_RX2_RY;
                n_state      = ST_S4;
            end
            ST_S4: begin
                o_cmd.wr_op  = WR_START_DEC;
                o_cmd.mul_op = MUL_RX2_RY2;
                n_state      = ST_S5;
            end
            ST_S5: begin
                o_cmd.wr_op = WR_C;
                n_state     = ST_IDLE;
            end
            ST_R1: begin
                o_cmd.mul_op = MUL_T_T;
                n_state      = ST_R2;
            end
            ST_R2: begin
                o_cmd.mul_op = MUL_RY2_P;
                n_state      = ST_R3;
            end
            ST_R3: begin
                o_cmd.wr_op  = WR_ACC;
                o_cmd.mul_op = MUL_U_U;
                n_state      = ST_R4;
            end
            ST_R4: begin
                o_cmd.mul_op = MUL_RX2_P;
                n_state      = ST_R5;
            end
            ST_R5: begin
                o_cmd.wr_op = WR_REGION_DEC;
                n_state     = ST_X1;
            end
            ST_X1: begin
                o_cmd.step_move = 1'b1;
                n_state         = ST_X2;
            end
            ST_X2: begin
                // hold until the result register can take the beat
                if (i_sts.out_free) begin
                    o_cmd.step_dec = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    `ASSERT_PROP(a_x1_active, i_clk, i_rst_n, (r_state == ST_X1) |-> i_sts.active)
    `ASSERT_PROP(a_r2_from_r5, i_clk, i_rst_n, $rose(i_sts.in_r2) |-> ($past(r_state) == ST_R5))
    `ASSERT_PROP(a_r1_region_one, i_clk, i_rst_n, (r_state == ST_R1) |-> (i_sts.active && !i_sts.in_r2))

endmodule

@@ hw/rtl/mer_dp.sv @@
// Datapath of the rasterizer: geometry, shared multiplier, offsets, decision
// variable and result register. Depends on mer_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mer_dp #(
    parameter int COORD_BITS  = mer_pkg::MER_COORD_BITS,
    parameter int RADIUS_BITS = mer_pkg::MER_RADIUS_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mer_pkg::t_mer_cmd          i_cmd,
    output mer_pkg::t_mer_sts          o_sts,
    input  logic [COORD_BITS-1:0]      i_center_x,
    input  logic [COORD_BITS-1:0]      i_center_y,
    input  logic [RADIUS_BITS-1:0]     i_radius_x,
    input  logic [RADIUS_BITS-1:0]     i_radius_y,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic [COORD_BITS:0]        o_col_plus,
    output logic signed [COORD_BITS:0] o_col_minus,
    output logic [COORD_BITS:0]        o_row_plus,
    output logic signed [COORD_BITS:0] o_row_minus,
    output logic                       o_region,
    output logic                       o_last
);
    import mer_pkg::*;

    localparam int R_W    = RADIUS_BITS;
    localparam int OUT_W  = COORD_BITS + 1;
    localparam int SQ_W   = 2 * R_W;
    localparam int A_W    = 2 * R_W;
    localparam int B_W    = 2 * R_W + 2;
    localparam int PROD_W = A_W + B_W;
    localparam int DX_W   = 3 * R_W + 2;
    localparam int C_W    = 4 * R_W;
    localparam int DEC_W  = 4 * R_W + 6;

    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [R_W-1:0]        r_rx;
    logic [R_W-1:0]        r_ry;
    logic [SQ_W-1:0]       r_rx2;
    logic [SQ_W-1:0]       r_ry2;
    logic [C_W-1:0]        r_c;
    logic [PROD_W-1:0]     r_prod;
    logic [PROD_W-1:0]     r_acc;
    logic [R_W-1:0]        r_x;
    logic [R_W-1:0]        r_y;
    logic [DX_W-1:0]       r_dx;
    logic [DX_W-1:0]       r_dy;
    logic [DEC_W-1:0]      r_dec;
    logic                  r_br;
    logic                  r_active;
    logic                  r_r2;
    logic                  r_ov;
    logic [OUT_W-1:0]      r_col_plus;
    logic signed [OUT_W-1:0] r_col_minus;
    logic [OUT_W-1:0]      r_row_plus;
    logic signed [OUT_W-1:0] r_row_minus;
    logic                  r_region;
    logic                  r_last;

    logic [A_W-1:0]    mul_a;
    logic [B_W-1:0]    mul_b;
    logic [PROD_W-1:0] mul_p;
    logic [R_W:0]      t_val;
    logic [R_W-1:0]    u_val;
    logic              dec_neg;
    logic              dec_pos;
    logic              move_x;
    logic              move_y;
    logic [R_W-1:0]    n_x;
    logic [R_W-1:0]    n_y;
    logic [DX_W-1:0]   n_dx;
    logic [DX_W-1:0]   n_dy;
    logic [DX_W-1:0]   term_dx;
    logic [SQ_W-1:0]   term_sq;
    logic [DX_W-1:0]   term_dy;
    logic [DEC_W-1:0]  n_start_dec;
    logic [DEC_W-1:0]  n_region_dec;
    logic [DEC_W-1:0]  n_step_dec;

    assign t_val = {r_x, 1'b1};
    assign u_val = r_y - R_W'(1);

    always_comb begin
        case (i_cmd.mul_op)
            MUL_RX_RX: begin
                mul_a = A_W'(r_rx);
                mul_b = B_W'(r_rx);
            end
            MUL_RY_RY: begin
                mul_a = A_W'(r_ry);
                mul_b = B_W'(r_ry);
            end
            MUL_RX2_RY: begin
                mul_a = r_rx2;
                mul_b = B_W'(r_ry);
            end
            MUL_RX2_RY2: begin
                mul_a = r_rx2;
                mul_b = B_W'(r_ry2);
            end
            MUL_T_T: begin
                mul_a = A_W'(t_val);
                mul_b = B_W'(t_val);
            end
            MUL_RY2_P: begin
                mul_a = r_ry2;
                mul_b = r_prod[B_W-1:0];
            end
            MUL_U_U: begin
                mul_a = A_W'(u_val);
                mul_b = B_W'(u_val);
            end
            MUL_RX2_P: begin
                mul_a = r_rx2;
                mul_b = r_prod[B_W-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign dec_neg = r_dec[DEC_W-1];
    assign dec_pos = !dec_neg && (r_dec != '0);
    assign move_x  = !r_r2 || !dec_pos;
    assign move_y  = r_r2 || !dec_neg;
    assign n_x     = move_x ? (r_x + R_W'(1)) : r_x;
    assign n_dx    = move_x ? (r_dx + DX_W'({r_ry2, 1'b0})) : r_dx;
    assign n_y     = move_y ? u_val : r_y;
    assign n_dy    = move_y ? (r_dy - DX_W'({r_rx2, 1'b0})) : r_dy;

    assign term_dx = (!r_r2 || r_br) ? r_dx : '0;
    assign term_sq = r_r2 ? r_rx2 : r_ry2;
    assign term_dy = (r_r2 || r_br) ? r_dy : '0;

    assign n_start_dec  = (DEC_W'(r_ry2) << 2) - (DEC_W'(r_prod) << 2) + DEC_W'(r_rx2);
    assign n_region_dec = DEC_W'(r_acc) + (DEC_W'(r_prod) << 2) - (DEC_W'(r_c) << 2);
    assign n_step_dec   = r_dec
                        + ((DEC_W'(term_dx) + DEC_W'(term_sq) - DEC_W'(term_dy)) << 2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_geom) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_rx <= i_radius_x;
            r_ry <= i_radius_y;
            r_x  <= '0;
            r_y  <= i_radius_y;
            r_dx <= '0;
        end
        if (i_cmd.mul_op != MUL_NONE) begin
            r_prod <= mul_p;
        end
        case (i_cmd.wr_op)
            WR_RX2: begin
                r_rx2 <= r_prod[SQ_W-1:0];
            end
            WR_RY2: begin
                r_ry2 <= r_prod[SQ_W-1:0];
            end
            WR_START_DEC: begin
                r_dy  <= DX_W'({r_prod, 1'b0});
                r_dec <= n_start_dec;
            end
            WR_C: begin
                r_c <= r_prod[C_W-1:0];
            end
            WR_ACC: begin
                r_acc <= r_prod;
            end
            WR_REGION_DEC: begin
                r_dec <= n_region_dec;
            end
            default: begin
            end
        endcase
        if (i_cmd.step_move) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_br <= r_r2 ? move_x : move_y;
        end
        if (i_cmd.step_dec) begin
            r_dec <= n_step_dec;
        end
        if (i_cmd.out_load) begin
            r_col_plus  <= OUT_W'(r_cx) + OUT_W'(r_x);
            r_col_minus <= $signed(OUT_W'(r_cx) - OUT_W'(r_x));
            r_row_plus  <= OUT_W'(r_cy) + OUT_W'(r_y);
            r_row_minus <= $signed(OUT_W'(r_cy) - OUT_W'(r_y));
            r_region    <= r_r2;
            r_last      <= (r_y == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_r2     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (i_cmd.load_geom) begin
                r_active <= 1'b0;
                r_r2     <= 1'b0;
            end else if (i_cmd.wr_op == WR_C) begin
                r_active <= (r_ry != '0);
            end else if (i_cmd.wr_op == WR_REGION_DEC) begin
                r_r2 <= 1'b1;
            end else if (i_cmd.out_load && (r_y == '0)) begin
                r_active <= 1'b0;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_sts.active   = r_active;
    assign o_sts.in_r2    = r_r2;
    assign o_sts.dx_ge_dy = (r_dx >= r_dy);
    assign o_sts.out_free = !r_ov || i_out_ready;

    assign o_out_valid = r_ov;
    assign o_col_plus  = r_col_plus;
    assign o_col_minus = r_col_minus;
    assign o_row_plus  = r_row_plus;
    assign o_row_minus = r_row_minus;
    assign o_region    = r_region;
    assign o_last      = r_last;

    `ASSERT_PROP(a_last_clears_active, i_clk, i_rst_n, (i_cmd.out_load && (r_y == '0)) |=> !r_active)
    `ASSERT_PROP(a_region_two_sticky, i_clk, i_rst_n, (r_r2 && !i_cmd.load_geom) |=> r_r2)
    `ASSERT_NEVER(a_no_dual_dec, i_clk, i_rst_n, i_cmd.step_dec && (i_cmd.wr_op != WR_NONE))

endmodule

@@ hw/rtl/midpoint_ellipse_rasterizer.sv @@
// Top level of the midpoint ellipse rasterizer: controller plus datapath.
// Depends on mer_pkg, mer_in_if, mer_out_if, mer_ctrl and mer_dp.
//
//   channel  dir  beat contents
//   i_in     in   cmd, center_x, center_y, radius_x, radius_y
//   o_res    out  col_plus, col_minus, row_plus, row_minus, region, last
//
// Start beat: 4 multiplies on one shared multiplier before the next beat is
// taken. Step beat: the step that enters region two first builds the
// region-two decision value on the multiplier.
// A step while idle gives no beat. Reset is synchronous and
// needs no clearing pass. A step waits in its last state while the result
// register holds a beat not yet taken.
module midpoint_ellipse_rasterizer #(
    parameter int COORD_BITS  = mer_pkg::MER_COORD_BITS,
    parameter int RADIUS_BITS = mer_pkg::MER_RADIUS_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mer_in_if.sink     i_in,
    mer_out_if.source  o_res
);
    import mer_pkg::*;

    t_mer_cmd dp_cmd;
    t_mer_sts dp_sts;

    mer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    mer_dp #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_center_x  (i_in.center_x),
        .i_center_y  (i_in.center_y),
        .i_radius_x  (i_in.radius_x),
        .i_radius_y  (i_in.radius_y),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_col_plus  (o_res.col_plus),
        .o_col_minus (o_res.col_minus),
        .o_row_plus  (o_res.row_plus),
        .o_row_minus (o_res.row_minus),
        .o_region    (o_res.region),
        .o_last      (o_res.last)
    );

endmodule

@@ verif/tb_top.sv @@
// Self-checking bench for midpoint_ellipse_rasterizer: queued start and step
// beats, a built-in ellipse stepper that predicts each point set, random stalls.
// Depends on mer_pkg, mer_in_if, mer_out_if and the rasterizer RTL.
module tb_top;
    import mer_pkg::*;

    typedef struct packed {
        bit        cmd;
        bit [11:0] cx;
        bit [11:0] cy;
        bit [9:0]  rx;
        bit [9:0]  ry;
        bit        drain;
    } ellipse_cmd_t;

    typedef struct packed {
        bit        busy;
        bit        in_r2;
        bit [63:0] ox;
        bit [63:0] oy;
        bit [63:0] dx;
        bit [63:0] dy;
        bit [63:0] dec;
        bit [63:0] cx;
        bit [63:0] cy;
        bit [63:0] rx;
        bit [63:0] ry;
    } ellipse_t;

    typedef struct packed {
        bit [12:0] col_p;
        bit [12:0] col_m;
        bit [12:0] row_p;
        bit [12:0] row_m;
        bit        region;
        bit        last;
    } point_set_t;

    bit clk;
    logic rst_n;

    mer_in_if  in_if ();
    mer_out_if res_if ();

    midpoint_ellipse_rasterizer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    ellipse_cmd_t cmd_queue[$];
    point_set_t   points_due[$];
    ellipse_t     plan;
    ellipse_t     shadow;
    ellipse_cmd_t in_flight;
    int           errors;
    int           n_live;
    int           send_gap;
    int           stall;
    bit           calm_tx;
    bit           calm_rx;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit next_point(inout ellipse_t e, input ellipse_cmd_t b,
                                      output point_set_t p);
        bit [63:0] rx2;
        bit [63:0] ry2;
        bit [63:0] t;
        bit        step_r2;
        bit        pos;
        p = '0;
        if (b.cmd == MER_CMD_START) begin
            e.cx = b.cx;
            e.cy = b.cy;
            e.rx = b.rx;
            e.ry = b.ry;
            rx2 = e.rx * e.rx;
            ry2 = e.ry * e.ry;
            e.ox = 0;
            e.oy = e.ry;
            e.dx = 0;
            e.dy = 2 * rx2 * e.ry;
            e.dec = 4 * ry2 - 4 * rx2 * e.ry + rx2;
            e.in_r2 = 1'b0;
            e.busy = (e.ry != 0);
            return 1'b0;
        end
        if (!e.busy) return 1'b0;
        rx2 = e.rx * e.rx;
        ry2 = e.ry * e.ry;
        if (!e.in_r2 && e.dx >= e.dy) begin
            t = 2 * e.ox + 1;
            e.dec = ry2 * t * t + 4 * rx2 * (e.oy - 1) * (e.oy - 1) - 4 * rx2 * ry2;
            e.in_r2 = 1'b1;
        end
        step_r2 = e.in_r2;
        if (!e.in_r2) begin
            e.ox += 1;
            e.dx = 2 * ry2 * e.ox;
            if (!e.dec[63]) begin
                e.oy -= 1;
                e.dy = 2 * rx2 * e.oy;
                e.dec += 4 * (e.dx - e.dy + ry2);
            end else begin
                e.dec += 4 * (e.dx + ry2);
            end
        end else begin
            pos = !e.dec[63] && (e.dec != 0);
            e.oy -= 1;
            e.dy = 2 * rx2 * e.oy;
            if (pos) begin
                e.dec += 4 * (rx2 - e.dy);
            end else begin
                e.ox += 1;
                e.dx = 2 * ry2 * e.ox;
                e.dec += 4 * (e.dx - e.dy + rx2);
            end
        end
        p.col_p  = 13'(e.cx + e.ox);
        p.col_m  = 13'(e.cx - e.ox);
        p.row_p  = 13'(e.cy + e.oy);
        p.row_m  = 13'(e.cy - e.oy);
        p.region = step_r2;
        p.last   = (e.oy == 0);
        if (e.oy == 0) e.busy = 1'b0;
        return 1'b1;
    endfunction

    task automatic queue_item(input bit cmd, input bit [11:0] cx, input bit [11:0] cy,
                              input bit [9:0] rx, input bit [9:0] ry, input bit drain);
        ellipse_cmd_t b;
        point_set_t   unused;
        b = '{cmd: cmd, cx: cx, cy: cy, rx: rx, ry: ry, drain: drain};
        if (cmd == MER_CMD_START || plan.busy) n_live++;
        void'(next_point(plan, b, unused));
        cmd_queue.push_back(b);
    endtask

    task automatic queue_ellipse(input bit [11:0] cx, input bit [11:0] cy,
                                 input bit [9:0] rx, input bit [9:0] ry,
                                 input int max_steps, input int extra, input bit drain);
        int n;
        queue_item(MER_CMD_START, cx, cy, rx, ry, drain);
        n = 0;
        while (n < max_steps && plan.busy) begin
            queue_item(MER_CMD_STEP, 12'($urandom), 12'($urandom), 10'($urandom),
                       10'($urandom), 1'b0);
            n++;
        end
        repeat (extra) begin
            queue_item(MER_CMD_STEP, 12'($urandom), 12'($urandom), 10'($urandom),
                       10'($urandom), 1'b0);
        end
    endtask

    task automatic check_field(input string name, input bit [12:0] want,
                               input bit [12:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
            errors++;
        end
    endtask

    // driver: predict on each accepted beat, then present the next one
    always @(posedge clk) begin
        point_set_t pt;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                if (next_point(shadow, in_flight, pt)) points_due.push_back(pt);
                if ($urandom_range(0, 39) == 0) calm_tx = !calm_tx;
                if (cmd_queue.size() > 60 && !calm_tx && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 18);
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (cmd_queue.size() != 0 &&
                             !(cmd_queue[0].drain && points_due.size() != 0)) begin
                    in_flight = cmd_queue.pop_front();
                    in_if.valid    <= 1'b1;
                    in_if.cmd      <= in_flight.cmd;
                    in_if.center_x <= in_flight.cx;
                    in_if.center_y <= in_flight.cy;
                    in_if.radius_x <= in_flight.rx;
                    in_if.radius_y <= in_flight.ry;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each point set beat, throttle ready in bursts
    always @(posedge clk) begin
        point_set_t got;
        point_set_t want;
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                got = '{col_p: res_if.col_plus, col_m: res_if.col_minus,
                        row_p: res_if.row_plus, row_m: res_if.row_minus,
                        region: res_if.region, last: res_if.last};
                if (points_due.size() == 0) begin
                    $display("%0t: unexpected point set, expected none, actual %p",
                             $time, got);
                    errors++;
                end else begin
                    want = points_due.pop_front();
                    check_field("col_plus", want.col_p, got.col_p);
                    check_field("col_minus", want.col_m, got.col_m);
                    check_field("row_plus", want.row_p, got.row_p);
                    check_field("row_minus", want.row_m, got.row_m);
                    check_field("region", 13'(want.region), 13'(got.region));
                    check_field("last", 13'(want.last), 13'(got.last));
                end
                if ($urandom_range(0, 29) == 0) calm_rx = !calm_rx;
            end
            if (stall > 0) begin
                stall--;
                res_if.ready <= 1'b0;
            end else if (cmd_queue.size() > 60 && !calm_rx && $urandom_range(0, 9) == 0) begin
                stall = $urandom_range(1, 18) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int pick;
        int long_runs;
        bit drain;
        rst_n          = 1'b0;
        in_if.valid    = 1'b0;
        in_if.cmd      = MER_CMD_START;
        in_if.center_x = '0;
        in_if.center_y = '0;
        in_if.radius_x = '0;
        in_if.radius_y = '0;
        res_if.ready   = 1'b0;
        plan   = '0;
        shadow = '0;
        long_runs = 0;

        // step before any start, extremes, zero radii, tiny ellipses
        queue_item(MER_CMD_STEP, 12'hFFF, 12'hFFF, 10'h3FF, 10'h3FF, 1'b0);
        queue_ellipse(12'd4095, 12'd4095, 10'd1023, 10'd1023, 3, 0, 1'b0);
        queue_ellipse(12'd0, 12'd0, 10'd1023, 10'd1023, 2, 0, 1'b0);
        queue_ellipse(12'd2048, 12'd2048, 10'd5, 10'd0, 10, 1, 1'b0);
        queue_ellipse(12'd100, 12'd200, 10'd0, 10'd3, 10, 1, 1'b1);
        queue_ellipse(12'd1, 12'd4094, 10'd1, 10'd1, 10, 0, 1'b0);
        queue_ellipse(12'd3000, 12'd17, 10'd4, 10'd2, 20, 0, 1'b0);

        while (n_live < 700) begin
            pick  = $urandom_range(0, 99);
            drain = ($urandom_range(0, 24) == 0);
            if (pick < 5) begin
                queue_item(MER_CMD_STEP, 12'($urandom), 12'($urandom), 10'($urandom),
                           10'($urandom), 1'b0);
            end else if (pick < 10) begin
                queue_ellipse(12'($urandom), 12'($urandom), 10'($urandom_range(1, 1023)),
                              10'($urandom_range(1, 1023)), $urandom_range(0, 30), 0, drain);
            end else if (pick < 12 && long_runs < 2) begin
                long_runs++;
                if (long_runs == 1)
                    queue_ellipse(12'($urandom), 12'($urandom), 10'($urandom_range(512, 1023)),
                                  10'($urandom_range(1, 8)), 700 - n_live, 0, drain);
                else
                    queue_ellipse(12'($urandom), 12'($urandom), 10'($urandom_range(1, 8)),
                                  10'($urandom_range(512, 1023)), 700 - n_live, 0, drain);
            end else begin
                queue_ellipse(12'($urandom), 12'($urandom), 10'($urandom_range(0, 24)),
                              10'($urandom_range(0, 24)), 4000,
                              ($urandom_range(0, 3) == 0) ? 1 : 0, drain);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || in_if.valid) @(posedge clk);
        while (points_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
